// ===== src/smms_pkg.sv =====
package smms_pkg;

    localparam int RamWordsDefault = 1024;

    localparam int AddrW    = 12;
    localparam int DataW    = 32;
    localparam int PendW    = 24;
    localparam int KindW    = 3;
    localparam int WordIdxW = 10;

    localparam logic [KindW-1:0] KindNone   = 3'd0;
    localparam logic [KindW-1:0] KindByte   = 3'd1;
    localparam logic [KindW-1:0] KindHalf   = 3'd2;
    localparam logic [KindW-1:0] KindWord   = 3'd3;
    localparam logic [KindW-1:0] KindTriple = 3'd4;

    localparam logic [1:0] OffB0 = 2'd0;
    localparam logic [1:0] OffB1 = 2'd1;
    localparam logic [1:0] OffB2 = 2'd2;
    localparam logic [1:0] OffB3 = 2'd3;

    typedef struct packed {
        logic             mem_enable;
        logic             mem_write;
        logic             reg_write;
        logic             load_misaligned;
        logic [KindW-1:0] kind;
        logic [1:0]       offset;
        logic [DataW-1:0] data;
    } op_t;

endpackage

// ===== src/smms_ram.sv =====
module smms_ram #(
    parameter int RAM_WORDS = smms_pkg::RamWordsDefault
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(RAM_WORDS)-1:0]   rd_addr,
    output logic [smms_pkg::DataW-1:0]     rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(RAM_WORDS)-1:0]   wr_addr,
    input  logic [smms_pkg::DataW-1:0]     wr_data,
    output logic                           busy
);

    localparam int IdxW = $clog2(RAM_WORDS);

    logic [smms_pkg::DataW-1:0] mem [RAM_WORDS];
    logic [smms_pkg::DataW-1:0] rd_data_reg;
    logic                       clr_busy_reg;
    logic [IdxW-1:0]            clr_idx_reg;
    logic                       mem_we;
    logic [IdxW-1:0]            mem_waddr;
    logic [smms_pkg::DataW-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == IdxW'(RAM_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_idx_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    // A write and a read of the same word at one edge return the new word.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= (mem_we && mem_waddr == rd_addr) ? mem_wdata : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

`ifndef SYNTHESIS
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("Clearing pass restarted without reset.");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !clr_busy_reg)
        else $error("Store write during the clearing pass.");
`endif

endmodule

// ===== src/smms_issue.sv =====
module smms_issue #(
    parameter int RAM_WORDS = smms_pkg::RamWordsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          load,
    input  logic                          mem_enable,
    input  logic                          mem_write,
    input  logic                          reg_write_in,
    input  logic                          load_misaligned,
    input  logic [smms_pkg::KindW-1:0]    access_kind,
    input  logic [smms_pkg::AddrW-1:0]    byte_address,
    input  logic [smms_pkg::DataW-1:0]    store_data,
    output logic                          valid,
    output smms_pkg::op_t                 op,
    output logic [$clog2(RAM_WORDS)-1:0]  idx,
    output logic                          split
);

    localparam int IdxW  = $clog2(RAM_WORDS);
    localparam int WIdxW = smms_pkg::WordIdxW;

    logic                          s1_valid_reg;
    logic                          s1_en_reg;
    logic                          s1_wr_reg;
    logic                          s1_rw_reg;
    logic                          s1_lm_reg;
    logic [smms_pkg::KindW-1:0]    s1_kind_reg;
    logic [smms_pkg::AddrW-1:0]    s1_addr_reg;
    logic [smms_pkg::DataW-1:0]    s1_data_reg;

    logic                          pending_valid_reg;
    logic [smms_pkg::KindW-1:0]    pending_kind_reg;
    logic [smms_pkg::AddrW-1:0]    pending_addr_reg;
    logic [smms_pkg::PendW-1:0]    pending_data_reg;

    logic [smms_pkg::KindW-1:0]    pending_kind_next;
    logic [smms_pkg::AddrW-1:0]    pending_addr_next;
    logic [smms_pkg::PendW-1:0]    pending_data_next;

    logic [smms_pkg::KindW-1:0]    eff_kind;
    logic [smms_pkg::AddrW-1:0]    eff_addr;
    logic [smms_pkg::DataW-1:0]    eff_data;
    logic [1:0]                    eff_off;
    logic [1:0]                    pend_step;

    function automatic logic [WIdxW-1:0] word_mod(input logic [WIdxW-1:0] w);
        logic [WIdxW-1:0] r;
        r = w;
        for (int k = WIdxW - 1; k >= 0; k--)
        begin
            if ((RAM_WORDS << k) < (1 << WIdxW))
            begin
                if (r >= WIdxW'(RAM_WORDS << k))
                begin
                    r = r - WIdxW'(RAM_WORDS << k);
                end
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            pending_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= load;
            if (s1_valid_reg)
            begin
                pending_valid_reg <= split;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            s1_en_reg   <= mem_enable;
            s1_wr_reg   <= mem_write;
            s1_rw_reg   <= reg_write_in;
            s1_lm_reg   <= load_misaligned;
            s1_kind_reg <= access_kind;
            s1_addr_reg <= byte_address;
            s1_data_reg <= store_data;
        end
        if (advance && s1_valid_reg && split)
        begin
            pending_kind_reg <= pending_kind_next;
            pending_addr_reg <= pending_addr_next;
            pending_data_reg <= pending_data_next;
        end
    end

    // A pending continuation takes the place of the transaction's own access.
    assign eff_kind = pending_valid_reg ? pending_kind_reg : s1_kind_reg;
    assign eff_addr = pending_valid_reg ? pending_addr_reg : s1_addr_reg;
    assign eff_data = pending_valid_reg ? smms_pkg::DataW'(pending_data_reg) : s1_data_reg;
    assign eff_off  = eff_addr[1:0];

    assign split = s1_en_reg && s1_wr_reg &&
                   ((eff_kind == smms_pkg::KindHalf && eff_off == smms_pkg::OffB3) ||
                    (eff_kind == smms_pkg::KindWord && eff_off != smms_pkg::OffB0));

    always_comb
    begin
        pend_step         = 2'd1;
        pending_kind_next = smms_pkg::KindByte;
        if (eff_kind == smms_pkg::KindWord)
        begin
            case (eff_off)
                smms_pkg::OffB1:
                begin
                    pend_step         = 2'd3;
                    pending_kind_next = smms_pkg::KindByte;
                end
                smms_pkg::OffB2:
                begin
                    pend_step         = 2'd2;
                    pending_kind_next = smms_pkg::KindHalf;
                end
                default:
                begin
                    pend_step         = 2'd1;
                    pending_kind_next = smms_pkg::KindTriple;
                end
            endcase
        end
    end

    // The continuation address follows the transaction's own address.
    assign pending_addr_next = s1_addr_reg + smms_pkg::AddrW'(pend_step);
    assign pending_data_next = smms_pkg::PendW'(eff_data >> {pend_step, 3'b000});

    assign op.mem_enable      = s1_en_reg;
    assign op.mem_write       = s1_wr_reg;
    assign op.reg_write       = s1_rw_reg;
    assign op.load_misaligned = s1_lm_reg;
    assign op.kind            = eff_kind;
    assign op.offset          = eff_off;
    assign op.data            = eff_data;

    assign idx   = IdxW'(word_mod(eff_addr[smms_pkg::AddrW-1:2]));
    assign valid = s1_valid_reg;

`ifndef SYNTHESIS
    a_split_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && split |=> pending_valid_reg)
        else $error("Split store did not leave a pending continuation.");

    a_replay_no_split: assert property (@(posedge clk) disable iff (!rst_n)
        pending_valid_reg |-> !split)
        else $error("Replayed continuation split again.");
`endif

endmodule

// ===== src/store_merge_misaligned_split.sv =====
// Store merge unit for the memory stage of a pipelined processor.
// Input transactions arrive on the s_axis channel: tdata carries the enable,
// store, register-write and misaligned-load flags, the byte address and the
// store data; tuser carries the access kind. Each accepted transaction gives
// exactly one result transaction on the m_axis channel with the RAM write
// flag, word index, merged word, stall flag and register-write flag.
// A store that crosses a word boundary writes its first part and raises the
// stall flag; the next transaction then replays the remainder in place of
// its own access kind, address and data.
// A transaction passes the issue and stage-two registers, and its result is held
// in the output registers. One transaction is accepted in every cycle while the
// receiver takes results and no clearing pass runs. The read-modify-write of the
// internal RAM is one registered read followed by one write, with the word being
// written forwarded to the read of a following transaction. After reset the unit
// clears its RAM, one word per cycle; s_axis_tready stays low during that pass.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready follows it low until the result is taken.
module store_merge_misaligned_split #(
    parameter int RAM_WORDS = smms_pkg::RamWordsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mem_enable, mem_write, reg_write_in, load_misaligned, byte_address, store_data
    input  logic [47:0] s_axis_tdata,
    // access_kind
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ram_write, write_word_index, write_word, stall_res, reg_write_out, zero fill
    output logic [47:0] m_axis_tdata
);

    localparam int IdxW = $clog2(RAM_WORDS);

    logic                          advance;
    logic                          load;
    logic                          clr_busy;
    logic                          s1_valid;
    smms_pkg::op_t                 s1_op;
    logic [IdxW-1:0]               s1_idx;
    logic                          s1_split;
    logic [smms_pkg::DataW-1:0]    old_word;

    logic                          s2_valid_reg;
    smms_pkg::op_t                 s2_op_reg;
    logic [IdxW-1:0]               s2_idx_reg;
    logic                          s2_split_reg;

    logic [3:0]                    byte_mask;
    logic [smms_pkg::DataW-1:0]    bit_mask;
    logic [smms_pkg::DataW-1:0]    aligned;
    logic [smms_pkg::DataW-1:0]    merged;
    logic                          wrote;
    logic                          ram_we;

    logic                          out_valid_reg;
    logic                          out_ram_write_reg;
    logic [smms_pkg::WordIdxW-1:0] out_idx_reg;
    logic [smms_pkg::DataW-1:0]    out_word_reg;
    logic                          out_stall_reg;
    logic                          out_rw_reg;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance && !clr_busy;
    assign load          = s_axis_tvalid && s_axis_tready;

    smms_issue #(
        .RAM_WORDS(RAM_WORDS)
    ) u_issue (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .load            (load),
        .mem_enable      (s_axis_tdata[0]),
        .mem_write       (s_axis_tdata[1]),
        .reg_write_in    (s_axis_tdata[2]),
        .load_misaligned (s_axis_tdata[3]),
        .access_kind     (s_axis_tuser),
        .byte_address    (s_axis_tdata[15:4]),
        .store_data      (s_axis_tdata[47:16]),
        .valid           (s1_valid),
        .op              (s1_op),
        .idx             (s1_idx),
        .split           (s1_split)
    );

    smms_ram #(
        .RAM_WORDS(RAM_WORDS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance && s1_valid),
        .rd_addr (s1_idx),
        .rd_data (old_word),
        .wr_en   (ram_we),
        .wr_addr (s2_idx_reg),
        .wr_data (merged),
        .busy    (clr_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg         <= s1_op;
            s2_idx_reg        <= s1_idx;
            s2_split_reg      <= s1_split;
            out_ram_write_reg <= wrote;
            out_idx_reg       <= wrote ? smms_pkg::WordIdxW'(s2_idx_reg) : '0;
            out_word_reg      <= wrote ? merged : '0;
            out_stall_reg     <= s2_split_reg;
            out_rw_reg        <= (s2_op_reg.load_misaligned &&
                                  s2_op_reg.kind != smms_pkg::KindNone) ?
                                 1'b0 : s2_op_reg.reg_write;
        end
    end

    always_comb
    begin
        case (s2_op_reg.kind)
            smms_pkg::KindByte:   byte_mask = 4'(4'b0001 << s2_op_reg.offset);
            smms_pkg::KindHalf:   byte_mask = 4'(4'b0011 << s2_op_reg.offset);
            smms_pkg::KindWord:   byte_mask = 4'(4'b1111 << s2_op_reg.offset);
            smms_pkg::KindTriple: byte_mask = 4'b0111;
            default:              byte_mask = 4'b0000;
        endcase
    end

    assign wrote = s2_op_reg.mem_enable && s2_op_reg.mem_write &&
                   (s2_op_reg.kind inside {smms_pkg::KindByte, smms_pkg::KindHalf,
                                           smms_pkg::KindWord, smms_pkg::KindTriple});

    // The three-byte continuation always lands in the low three bytes.
    assign aligned  = (s2_op_reg.kind == smms_pkg::KindTriple) ? s2_op_reg.data :
                      (s2_op_reg.data << {s2_op_reg.offset, 3'b000});
    assign bit_mask = {{8{byte_mask[3]}}, {8{byte_mask[2]}},
                       {8{byte_mask[1]}}, {8{byte_mask[0]}}};
    assign merged   = (old_word & ~bit_mask) | (aligned & bit_mask);
    assign ram_we   = advance && s2_valid_reg && wrote;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_rw_reg, out_stall_reg, out_word_reg,
                            out_idx_reg, out_ram_write_reg};

`ifndef SYNTHESIS
    a_stall_has_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall_reg |-> out_ram_write_reg)
        else $error("Stall raised without writing the first part.");
`endif

endmodule
